// File: rtl/core/map_2d_linear_interpolator_unit_macros.svh
// Assertion macros used by the checker file of the 2-D interpolator.
// No dependencies; each macro expands to one labeled concurrent assertion.
`ifndef MAP_2D_LINEAR_INTERPOLATOR_UNIT_MACROS_SVH
`define MAP_2D_LINEAR_INTERPOLATOR_UNIT_MACROS_SVH

// same-cycle implication, clocked on clock, disabled in reset
`define M2LI_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("m2li check failed");

// next-cycle implication
`define M2LI_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("m2li check failed");

`endif

// File: rtl/core/m2li_pkg.sv
// Package of the 2-D table interpolator: sizes, codes, types and helpers.
// Used by every module of the block but m2li_ram; depends on nothing.
package m2li_pkg;

   localparam int DATA_W     = 48;
   localparam int MAX_ROWS   = 16;
   localparam int MAX_PTS    = 32;
   localparam int FRAC_BITS  = 16;
   localparam int ROW_IDX_W  = $clog2(MAX_ROWS);
   localparam int ROW_CNT_W  = $clog2(MAX_ROWS + 1);
   localparam int PT_IDX_W   = $clog2(MAX_PTS);
   localparam int PT_CNT_W   = $clog2(MAX_PTS + 1);
   localparam int ADDR_W     = ROW_IDX_W + PT_IDX_W;
   localparam int MEM_DEPTH  = MAX_ROWS * MAX_PTS;
   localparam int OP_W       = DATA_W + 2;
   localparam int PROD_W     = 2 * OP_W;
   localparam int MD_CNT_W   = $clog2(PROD_W);
   localparam int REQ_DATA_W = 3 * DATA_W;
   localparam int OPC_W      = 2;
   localparam int STAT_W     = 2;

   typedef logic signed [DATA_W-1:0] word_type;
   typedef logic signed [OP_W-1:0]   wide_type;

   localparam wide_type FRAC_ONE = wide_type'(1) <<< FRAC_BITS;
   localparam word_type WORD_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam word_type WORD_MIN = {1'b1, {(DATA_W-1){1'b0}}};

   typedef enum logic [OPC_W-1:0] {
      OP_WRITE   = 2'd0,
      OP_VALUE   = 2'd1,
      OP_SLOPE_X = 2'd2,
      OP_SLOPE_Y = 2'd3
   } opcode_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK        = 2'd0,
      STAT_EMPTY     = 2'd1,
      STAT_ROWS_FULL = 2'd2,
      STAT_ROW_FULL  = 2'd3
   } status_type;

   typedef enum logic [4:0] {
      S_IDLE, S_WROW, S_WROWINS, S_PSETUP, S_PRD, S_PCMP, S_WPOINT, S_SHRD, S_SHWR,
      S_WINS, S_QROW, S_QCALC, S_QWAIT, S_QNEXT, S_OUTER, S_OWAIT, S_FINISH
   } state_type;

   typedef enum logic [1:0] {
      MD_IDLE, MD_MUL, MD_DIV, MD_DONE
   } md_state_type;

   // operands of one trunc(a * b / d), d > 0
   typedef struct packed {
      wide_type          a;
      wide_type          b;
      logic [OP_W-1:0]   d;
   } md_req_type;

   function automatic wide_type widen(input word_type v);
      return {{(OP_W-DATA_W){v[DATA_W-1]}}, v};
   endfunction

   function automatic word_type saturate(input wide_type v);
      word_type r;
      if (v > widen(WORD_MAX)) begin
         r = WORD_MAX;
      end else if (v < widen(WORD_MIN)) begin
         r = WORD_MIN;
      end else begin
         r = v[DATA_W-1:0];
      end
      return r;
   endfunction

endpackage

// File: rtl/core/m2li_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Standalone; used for the point key and point value stores.
module m2li_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: rtl/core/m2li_muldiv.sv
// Bit-serial multiply-then-divide unit: sat48(trunc(a * b / d)), exact product.
// Depends on m2li_pkg. Shift-add multiply, then restoring division one bit a cycle.
module m2li_muldiv import m2li_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  md_req_type req,
   output logic       done,
   output word_type   quot
);

   md_state_type        st_ff;
   logic [MD_CNT_W-1:0] cnt_ff;
   logic [PROD_W-1:0]   mcand_ff;
   logic [OP_W-1:0]     mplier_ff;
   logic [PROD_W-1:0]   prod_ff;
   logic [OP_W-1:0]     div_ff;
   logic [OP_W-1:0]     rem_ff;
   logic [DATA_W-1:0]   q_ff;
   logic                big_ff;
   logic                neg_ff;

   logic [OP_W-1:0]     mag_a;
   logic [OP_W-1:0]     mag_b;
   logic [OP_W:0]       trial;
   logic                qbit;
   logic [OP_W:0]       trial_sub;

   assign mag_a     = req.a[OP_W-1] ? OP_W'(-req.a) : OP_W'(req.a);
   assign mag_b     = req.b[OP_W-1] ? OP_W'(-req.b) : OP_W'(req.b);
   assign trial     = {rem_ff, prod_ff[PROD_W-1]};
   assign qbit      = trial >= {1'b0, div_ff};
   assign trial_sub = trial - {1'b0, div_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= MD_IDLE;
      end else begin
         unique case (st_ff)
            MD_IDLE: begin
               if (start) begin
                  mcand_ff  <= {{(PROD_W-OP_W){1'b0}}, mag_a};
                  mplier_ff <= mag_b;
                  prod_ff   <= '0;
                  div_ff    <= req.d;
                  neg_ff    <= req.a[OP_W-1] ^ req.b[OP_W-1];
                  cnt_ff    <= MD_CNT_W'(OP_W - 1);
                  st_ff     <= MD_MUL;
               end
            end
            MD_MUL: begin
               if (mplier_ff[0]) begin
                  prod_ff <= prod_ff + mcand_ff;
               end
               mcand_ff  <= {mcand_ff[PROD_W-2:0], 1'b0};
               mplier_ff <= {1'b0, mplier_ff[OP_W-1:1]};
               if (cnt_ff == '0) begin
                  cnt_ff <= MD_CNT_W'(PROD_W - 1);
                  rem_ff <= '0;
                  q_ff   <= '0;
                  big_ff <= 1'b0;
                  st_ff  <= MD_DIV;
               end else begin
                  cnt_ff <= cnt_ff - MD_CNT_W'(1);
               end
            end
            MD_DIV: begin
               rem_ff  <= qbit ? trial_sub[OP_W-1:0] : trial[OP_W-1:0];
               prod_ff <= {prod_ff[PROD_W-2:0], 1'b0};
               q_ff    <= {q_ff[DATA_W-2:0], qbit};
               // quotient bits above the result width only mark overflow
               if (qbit && cnt_ff >= MD_CNT_W'(DATA_W)) begin
                  big_ff <= 1'b1;
               end
               if (cnt_ff == '0) begin
                  st_ff <= MD_DONE;
               end else begin
                  cnt_ff <= cnt_ff - MD_CNT_W'(1);
               end
            end
            MD_DONE: begin
               st_ff <= MD_IDLE;
            end
            default: begin
               st_ff <= MD_IDLE;
            end
         endcase
      end
   end

   assign done = st_ff == MD_DONE;

   always_comb begin
      if (neg_ff) begin
         quot = (big_ff || (q_ff[DATA_W-1] && |q_ff[DATA_W-2:0])) ? WORD_MIN : word_type'(-q_ff);
      end else begin
         quot = (big_ff || q_ff[DATA_W-1]) ? WORD_MAX : word_type'(q_ff);
      end
   end

endmodule

// File: rtl/core/map_2d_linear_interpolator_unit.sv
// Top level of the 2-D lookup table with linear interpolation.
// Depends on m2li_pkg, m2li_ram (point key/value stores) and m2li_muldiv.
//
// Usage:
//   req_* : one transaction per operation. tuser = operation (write point,
//           query value, slope along x, slope along y); tdata = key_x, key_y,
//           point_value. Exactly one rsp_* transaction follows each request.
//   rsp_* : tdata = result (saturated Q32.16), tuser = status.
//   Row keys, point counts and the logical-to-physical row map sit in flops;
//   points live in two 512-entry RAMs addressed by {physical row, position}.
//   A write scans the rows, then the points of its row, then overwrites an
//   equal key's value or shifts the later points up and inserts. A query
//   scans the rows, then for each bracketing row scans its points and may
//   run a multiply/divide, then may run one more for the pass across x.
//   The serial unit multiplies first, then divides.
//   One request at a time; the next is taken once the result sits in the
//   output register, even while rsp_tready is low.
//   Reset empties the table at once (no clearing pass); a stalled result is
//   held in the output register until taken.
module map_2d_linear_interpolator_unit import m2li_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // key_x, key_y, point_value
   input  logic [OPC_W-1:0]      req_tuser,   // operation
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [DATA_W-1:0]     rsp_tdata,   // result_value
   output logic [STAT_W-1:0]     rsp_tuser    // status
);

   state_type            st_ff, st_in;
   opcode_type           op_ff;
   word_type             kx_ff, ky_ff, pv_ff;
   logic [ROW_CNT_W-1:0] rows_used_ff;
   word_type             row_key_ff  [MAX_ROWS];
   logic [PT_CNT_W-1:0]  row_cnt_ff  [MAX_ROWS];
   logic [ROW_IDX_W-1:0] row_slot_ff [MAX_ROWS];
   logic [ROW_CNT_W-1:0] idx_ff, hi_idx_ff;
   logic                 row_new_ff;
   word_type             prev_rk_ff, xl_ff, xh_ff;
   logic [ROW_IDX_W-1:0] slot_ff;
   logic [PT_CNT_W-1:0]  n_ff, p_ff, j_ff;
   logic                 eq_ff;
   word_type             prev_pk_ff, prev_pv_ff;
   word_type             klo_ff, vlo_ff, khi_ff, vhi_ff;
   logic                 phase_ff;
   wide_type             rowval_ff, rv0_ff, rv1_ff, res_ff;
   status_type           status_ff;
   logic                 rsp_tvalid_ff;
   word_type             rsp_data_ff;
   status_type           rsp_user_ff;

   word_type             cur_rk;
   logic [PT_CNT_W-1:0]  cur_cnt;
   logic [ROW_IDX_W-1:0] cur_slot;
   logic                 row_ge, row_last, rows_full, at_end;
   word_type             pt_key, pt_val;
   logic                 pt_ge, pt_last;
   logic [PT_CNT_W-1:0]  jm1;
   logic                 is_write, slope_y, slope_x, rsp_free;
   logic [DATA_W-1:0]    key_rdata, val_rdata, key_wdata, val_wdata;
   logic [ADDR_W-1:0]    raddr, waddr;
   logic                 key_we, val_we;
   logic                 md_start, md_done;
   md_req_type           md_req;
   word_type             md_quot;

   assign cur_rk    = row_key_ff[idx_ff[ROW_IDX_W-1:0]];
   assign cur_cnt   = row_cnt_ff[idx_ff[ROW_IDX_W-1:0]];
   assign cur_slot  = row_slot_ff[idx_ff[ROW_IDX_W-1:0]];
   assign row_ge    = cur_rk >= kx_ff;
   assign row_last  = idx_ff == rows_used_ff - ROW_CNT_W'(1);
   assign at_end    = idx_ff == rows_used_ff;
   assign rows_full = rows_used_ff == ROW_CNT_W'(MAX_ROWS);
   assign pt_key    = word_type'(key_rdata);
   assign pt_val    = word_type'(val_rdata);
   assign pt_ge     = pt_key >= ky_ff;
   assign pt_last   = p_ff == n_ff - PT_CNT_W'(1);
   assign jm1       = j_ff - PT_CNT_W'(1);
   assign is_write  = op_ff == OP_WRITE;
   assign slope_y   = op_ff == OP_SLOPE_Y;
   assign slope_x   = op_ff == OP_SLOPE_X;
   assign rsp_free  = !rsp_tvalid_ff || rsp_tready;

   // next state
   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               if (opcode_type'(req_tuser) == OP_WRITE) begin
                  st_in = S_WROW;
               end else if (rows_used_ff == '0) begin
                  st_in = S_FINISH;
               end else begin
                  st_in = S_QROW;
               end
            end
         end
         S_WROW:    if (at_end || row_ge) st_in = S_WROWINS;
         S_WROWINS: st_in = (row_new_ff && rows_full) ? S_FINISH : S_PSETUP;
         S_PSETUP:  st_in = (!is_write && cur_cnt == '0) ? S_QNEXT : S_PRD;
         S_PRD:     st_in = (p_ff == n_ff) ? S_WPOINT : S_PCMP;
         S_PCMP: begin
            if (is_write) begin
               st_in = pt_ge ? S_WPOINT : S_PRD;
            end else begin
               st_in = (pt_ge || pt_last) ? S_QCALC : S_PRD;
            end
         end
         S_WPOINT: begin
            if (eq_ff || n_ff == PT_CNT_W'(MAX_PTS)) begin
               st_in = S_FINISH;
            end else if (n_ff == p_ff) begin
               st_in = S_WINS;
            end else begin
               st_in = S_SHRD;
            end
         end
         S_SHRD:   st_in = S_SHWR;
         S_SHWR:   st_in = (jm1 == p_ff) ? S_WINS : S_SHRD;
         S_WINS:   st_in = S_FINISH;
         S_QROW:   if (row_ge || row_last) st_in = S_PSETUP;
         S_QCALC:  st_in = (klo_ff == khi_ff) ? S_QNEXT : S_QWAIT;
         S_QWAIT:  if (md_done) st_in = S_QNEXT;
         S_QNEXT:  st_in = phase_ff ? S_OUTER : S_PSETUP;
         S_OUTER:  st_in = (xl_ff == xh_ff) ? S_FINISH : S_OWAIT;
         S_OWAIT:  if (md_done) st_in = S_FINISH;
         S_FINISH: if (rsp_free) st_in = S_IDLE;
         default:  st_in = S_IDLE;
      endcase
   end

   // memory, divider and handshake controls
   always_comb begin
      req_tready = st_ff == S_IDLE;
      raddr      = {slot_ff, p_ff[PT_IDX_W-1:0]};
      waddr      = {slot_ff, p_ff[PT_IDX_W-1:0]};
      key_we     = 1'b0;
      val_we     = 1'b0;
      key_wdata  = ky_ff;
      val_wdata  = pv_ff;
      md_start   = 1'b0;
      md_req.a   = widen(vhi_ff) - widen(vlo_ff);
      md_req.b   = slope_y ? FRAC_ONE : widen(ky_ff) - widen(klo_ff);
      md_req.d   = OP_W'(widen(khi_ff) - widen(klo_ff));
      unique case (st_ff)
         S_SHRD: begin
            raddr = {slot_ff, jm1[PT_IDX_W-1:0]};
         end
         S_SHWR: begin
            waddr     = {slot_ff, j_ff[PT_IDX_W-1:0]};
            key_we    = 1'b1;
            val_we    = 1'b1;
            key_wdata = key_rdata;
            val_wdata = val_rdata;
         end
         S_WINS: begin
            key_we = 1'b1;
            val_we = 1'b1;
         end
         S_WPOINT: begin
            val_we = eq_ff;
         end
         S_QCALC: begin
            md_start = klo_ff != khi_ff;
         end
         S_OUTER: begin
            md_start = xl_ff != xh_ff;
            md_req.a = rv1_ff - rv0_ff;
            md_req.b = slope_x ? FRAC_ONE : widen(kx_ff) - widen(xl_ff);
            md_req.d = OP_W'(widen(xh_ff) - widen(xl_ff));
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff         <= S_IDLE;
         rows_used_ff  <= '0;
         rsp_tvalid_ff <= 1'b0;
         for (int i = 0; i < MAX_ROWS; i++) begin
            row_cnt_ff[i] <= '0;
         end
      end else begin
         st_ff <= st_in;
         if (st_ff == S_FINISH && rsp_free) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
         unique case (st_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  op_ff     <= opcode_type'(req_tuser);
                  kx_ff     <= req_tdata[DATA_W-1:0];
                  ky_ff     <= req_tdata[2*DATA_W-1:DATA_W];
                  pv_ff     <= req_tdata[3*DATA_W-1:2*DATA_W];
                  idx_ff    <= '0;
                  res_ff    <= '0;
                  status_ff <= (opcode_type'(req_tuser) != OP_WRITE && rows_used_ff == '0)
                               ? STAT_EMPTY : STAT_OK;
               end
            end
            S_WROW: begin
               if (at_end) begin
                  row_new_ff <= 1'b1;
               end else if (row_ge) begin
                  row_new_ff <= cur_rk != kx_ff;
               end else begin
                  idx_ff <= idx_ff + ROW_CNT_W'(1);
               end
            end
            S_WROWINS: begin
               if (row_new_ff) begin
                  if (rows_full) begin
                     status_ff <= STAT_ROWS_FULL;
                  end else begin
                     // open a row at idx; new rows take the next free physical slot
                     for (int i = 1; i < MAX_ROWS; i++) begin
                        if (ROW_CNT_W'(i) > idx_ff) begin
                           row_key_ff[i]  <= row_key_ff[i-1];
                           row_cnt_ff[i]  <= row_cnt_ff[i-1];
                           row_slot_ff[i] <= row_slot_ff[i-1];
                        end
                     end
                     row_key_ff[idx_ff[ROW_IDX_W-1:0]]  <= kx_ff;
                     row_cnt_ff[idx_ff[ROW_IDX_W-1:0]]  <= '0;
                     row_slot_ff[idx_ff[ROW_IDX_W-1:0]] <= rows_used_ff[ROW_IDX_W-1:0];
                     rows_used_ff <= rows_used_ff + ROW_CNT_W'(1);
                  end
               end
            end
            S_PSETUP: begin
               slot_ff   <= cur_slot;
               n_ff      <= cur_cnt;
               p_ff      <= '0;
               rowval_ff <= '0;
            end
            S_PRD: begin
               if (p_ff == n_ff) begin
                  eq_ff <= 1'b0;
               end
            end
            S_PCMP: begin
               if (is_write) begin
                  if (pt_ge) begin
                     eq_ff <= pt_key == ky_ff;
                  end else begin
                     p_ff <= p_ff + PT_CNT_W'(1);
                  end
               end else if (pt_ge || pt_last) begin
                  khi_ff <= pt_key;
                  vhi_ff <= pt_val;
                  klo_ff <= (pt_ge && p_ff != '0) ? prev_pk_ff : pt_key;
                  vlo_ff <= (pt_ge && p_ff != '0) ? prev_pv_ff : pt_val;
               end else begin
                  prev_pk_ff <= pt_key;
                  prev_pv_ff <= pt_val;
                  p_ff       <= p_ff + PT_CNT_W'(1);
               end
            end
            S_WPOINT: begin
               j_ff <= n_ff;
               if (!eq_ff && n_ff == PT_CNT_W'(MAX_PTS)) begin
                  status_ff <= STAT_ROW_FULL;
               end
            end
            S_SHWR: begin
               j_ff <= jm1;
            end
            S_WINS: begin
               row_cnt_ff[idx_ff[ROW_IDX_W-1:0]] <= n_ff + PT_CNT_W'(1);
            end
            S_QROW: begin
               if (row_ge || row_last) begin
                  phase_ff  <= 1'b0;
                  hi_idx_ff <= idx_ff;
                  xh_ff     <= cur_rk;
                  if (row_ge && idx_ff != '0) begin
                     idx_ff <= idx_ff - ROW_CNT_W'(1);
                     xl_ff  <= prev_rk_ff;
                  end else begin
                     xl_ff <= cur_rk;
                  end
               end else begin
                  prev_rk_ff <= cur_rk;
                  idx_ff     <= idx_ff + ROW_CNT_W'(1);
               end
            end
            S_QCALC: begin
               if (klo_ff == khi_ff) begin
                  rowval_ff <= slope_y ? '0 : widen(vlo_ff);
               end
            end
            S_QWAIT: begin
               if (md_done) begin
                  rowval_ff <= slope_y ? widen(md_quot) : widen(vlo_ff) + widen(md_quot);
               end
            end
            S_QNEXT: begin
               if (!phase_ff) begin
                  rv0_ff   <= rowval_ff;
                  phase_ff <= 1'b1;
                  idx_ff   <= hi_idx_ff;
               end else begin
                  rv1_ff <= rowval_ff;
               end
            end
            S_OUTER: begin
               if (xl_ff == xh_ff) begin
                  res_ff <= slope_x ? '0 : rv0_ff;
               end
            end
            S_OWAIT: begin
               if (md_done) begin
                  res_ff <= slope_x ? widen(md_quot) : rv0_ff + widen(md_quot);
               end
            end
            S_FINISH: begin
               if (rsp_free) begin
                  rsp_data_ff <= saturate(res_ff);
                  rsp_user_ff <= status_ff;
               end
            end
            default: begin
            end
         endcase
      end
   end

   m2li_ram #(.WIDTH(DATA_W), .DEPTH(MEM_DEPTH)) u_key_ram (
      .clock (clock),
      .we    (key_we),
      .waddr (waddr),
      .wdata (key_wdata),
      .raddr (raddr),
      .rdata (key_rdata)
   );

   m2li_ram #(.WIDTH(DATA_W), .DEPTH(MEM_DEPTH)) u_val_ram (
      .clock (clock),
      .we    (val_we),
      .waddr (waddr),
      .wdata (val_wdata),
      .raddr (raddr),
      .rdata (val_rdata)
   );

   m2li_muldiv u_muldiv (
      .clock (clock),
      .reset (reset),
      .start (md_start),
      .req   (md_req),
      .done  (md_done),
      .quot  (md_quot)
   );

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

// File: rtl/core/m2li_checker.sv
// Port-level checker for the 2-D interpolator, bound to the top level.
// Depends on m2li_pkg and map_2d_linear_interpolator_unit_macros.svh.
`include "map_2d_linear_interpolator_unit_macros.svh"

module m2li_checker import m2li_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [DATA_W-1:0]     rsp_tdata,
   input logic [STAT_W-1:0]     rsp_tuser
);

   // a stalled result holds
   `M2LI_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid)
   `M2LI_ASSERT_NEXT(a_rsp_stable, rsp_tvalid && !rsp_tready, $stable(rsp_tdata) && $stable(rsp_tuser))
   // one transaction at a time: busy right after taking a request
   `M2LI_ASSERT_NEXT(a_busy_after_req, req_tvalid && req_tready, !req_tready)
   // any error status carries a zero result
   `M2LI_ASSERT_IMPL(a_err_zero, rsp_tvalid && rsp_tuser != STAT_OK, rsp_tdata == '0)

endmodule

bind map_2d_linear_interpolator_unit m2li_checker u_checker (.*);
